FILE: src/staba_pkg.sv
// Shared constants and codes for the sample threshold alarm / block averager.
// No dependencies; imported by sample_threshold_alarm_block_averager_unit.
package staba_pkg;

    localparam int SAMPLE_W = 12;
    localparam int THRESH_W = 12;
    localparam int IVL_W    = 10;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 16;
    localparam int AVG_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [THRESH_W-1:0] THRESH_CLAMP = 12'd1800;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd4000;
    localparam logic [IVL_W-1:0]    IVL_RESET    = 10'd1;
    localparam logic [IVL_W-1:0]    SINCE_RESET  = 10'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd1;

    // result word kinds
    typedef enum logic {
        KIND_ALARM   = 1'b0,
        KIND_AVERAGE = 1'b1
    } kind_t;

endpackage

FILE: src/sample_threshold_alarm_block_averager_unit.sv
// Top level of the sample threshold alarm with decimated block averager.
// Depends on staba_pkg for widths, register indexes and result kinds.
//
// Usage:
//   Input channel (in_valid / in_stall / sample) carries one 12-bit converter
//   sample per word. Output channel (out_valid / out_stall / kind / average)
//   carries at most one result word per sample: an alarm (kind 0, average 0)
//   when ten times the sample exceeds the threshold, or a block average times
//   ten (kind 1) for every send_interval-th completed block of BLOCK_SIZE
//   samples. Samples that raise no word are absorbed silently.
//   Configuration: cfg_write with cfg_index / cfg_data, one register per
//   write, only while idle. Threshold writes above 1800 store 1800; unknown
//   indexes are ignored.
// Timing:
//   Two register stages. Stage one does the threshold compare, sum/count
//   update and decimation decision; stage two does the divide by BLOCK_SIZE
//   (reciprocal multiply, 18x19 bits) and the scale by ten into the output
//   register. A result word moves from the middle stage into the output
//   register once the output is free; out_stall can hold it in the middle stage.
//   One sample per cycle while in_stall stays low; the reciprocal
//   multiplier sets the critical path.
// Stall: out_stall holds the output word; the middle stage still fills, and
//   in_stall rises only when both the middle stage and output are occupied.
// Reset (rst_n low, async): threshold 4000, interval 1, sum and count 0,
//   decimation counter 1, both pipeline stages empty.
module sample_threshold_alarm_block_averager_unit #(
    parameter int BLOCK_SIZE = 25
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [staba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [staba_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [staba_pkg::SAMPLE_W-1:0]        sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  kind,
    output logic [staba_pkg::AVG_W-1:0]           average
);
    import staba_pkg::*;

    // Exact divide of any SUM_W-bit value by BLOCK_SIZE:
    // q = (x * RECIP) >> SHIFT, RECIP = ceil(2^SHIFT / BLOCK_SIZE).
    localparam int SHIFT   = SUM_W + $clog2(BLOCK_SIZE);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + longint'(BLOCK_SIZE) - 64'd1) / longint'(BLOCK_SIZE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [CNT_W-1:0]   BLOCK_CNT = CNT_W'(BLOCK_SIZE);

    // configuration
    logic [THRESH_W-1:0] thr_reg;
    logic [IVL_W-1:0]    ivl_reg;
    logic [THRESH_W-1:0] cfg_thr;

    // accumulation state
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IVL_W-1:0]    since_reg, since_next;

    // middle stage
    logic                mid_valid_reg, mid_valid_next;
    kind_t               mid_kind_reg,  mid_kind_next;
    logic [SUM_W-1:0]    mid_sum_reg,   mid_sum_next;

    // output stage
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [AVG_W-1:0]    out_avg_reg,   out_avg_next;

    logic                in_accept;
    logic                out_free;
    logic                mid_move;
    logic [AVG_W-1:0]    sample_x10;
    logic                alarm;
    logic [SUM_W-1:0]    acc_sum;
    logic [CNT_W-1:0]    acc_count;
    logic                block_done;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   quot_wide;
    logic [SUM_W-1:0]    quot;

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign mid_move  = mid_valid_reg && out_free;
    assign in_stall  = mid_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign average   = out_avg_reg;

    // clamp threshold writes
    assign cfg_thr = (cfg_data > THRESH_CLAMP) ? THRESH_CLAMP : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
            ivl_reg <= IVL_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_THRESHOLD)
            begin
                thr_reg <= cfg_thr;
            end
            else if (cfg_index == REG_INTERVAL)
            begin
                ivl_reg <= cfg_data[IVL_W-1:0];
            end
        end
    end

    // stage one: alarm compare, accumulate, decimate
    assign sample_x10 = {1'b0, sample, 3'b000} + {3'b000, sample, 1'b0};
    assign alarm      = sample_x10 > {{(AVG_W-THRESH_W){1'b0}}, thr_reg};
    assign acc_sum    = sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
    assign acc_count  = count_reg + CNT_W'(1);
    assign block_done = (acc_count == BLOCK_CNT) && (thr_reg != '0);

    always_comb
    begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        since_next     = since_reg;
        mid_kind_next  = mid_kind_reg;
        mid_sum_next   = mid_sum_reg;
        mid_valid_next = mid_move ? 1'b0 : mid_valid_reg;
        if (in_accept)
        begin
            if (alarm)
            begin
                mid_valid_next = 1'b1;
                mid_kind_next  = KIND_ALARM;
            end
            else if (block_done)
            begin
                sum_next     = '0;
                count_next   = '0;
                mid_sum_next = acc_sum;
                if (since_reg >= ivl_reg)
                begin
                    since_next     = SINCE_RESET;
                    mid_valid_next = 1'b1;
                    mid_kind_next  = KIND_AVERAGE;
                end
                else
                begin
                    since_next = since_reg + IVL_W'(1);
                end
            end
            else
            begin
                sum_next   = acc_sum;
                count_next = acc_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            since_reg     <= SINCE_RESET;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            since_reg     <= since_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_kind_reg <= mid_kind_next;
        mid_sum_reg  <= mid_sum_next;
    end

    // stage two: divide by block size, scale by ten (mod 2^16)
    assign prod      = {{RECIP_W{1'b0}}, mid_sum_reg} * {{SUM_W{1'b0}}, RECIP};
    assign quot_wide = prod >> SHIFT;
    assign quot      = quot_wide[SUM_W-1:0];

    always_comb
    begin
        out_avg_next = '0;
        if (mid_kind_reg == KIND_AVERAGE)
        begin
            out_avg_next = {quot[AVG_W-4:0], 3'b000} + {quot[AVG_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_move)
        begin
            out_kind_reg <= mid_kind_reg;
            out_avg_reg  <= out_avg_next;
        end
    end

    // checks
    a_thr_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (thr_reg <= THRESH_CLAMP) || (thr_reg == THRESH_RESET))
        else $error("threshold register holds an unclamped value");

    a_since_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        since_reg != '0)
        else $error("decimation counter reached zero");

    a_alarm_to_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && alarm) |=> (mid_valid_reg && (mid_kind_reg == KIND_ALARM)))
        else $error("alarm word not captured in middle stage");

    a_mid_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        mid_move |=> (out_valid_reg && (out_kind_reg == $past(mid_kind_reg))))
        else $error("middle stage word lost on its way to the output");

endmodule

FILE: bench/tb_sample_threshold_alarm_block_averager_unit.sv
// Self-checking bench for sample_threshold_alarm_block_averager_unit.
// Depends on staba_pkg and the unit; runs a stimulus table, random phases and a zero-threshold run.
module tb_sample_threshold_alarm_block_averager_unit;

    import staba_pkg::*;

    localparam int BLOCK_SIZE   = 25;
    localparam int SCALE        = 10;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int SETTLE       = 4;     // two pipe stages plus margin
    localparam int LONG_HOLD    = 200;   // receiver hold-off under pressure
    localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int ROWS         = 23;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        kind_t              kind;
        logic [AVG_W-1:0]   average;
    } result_word_t;

    typedef enum logic {
        OP_SAMPLE,
        OP_WRITE
    } row_op_t;

    // how a table row gets its expected word
    typedef enum logic [1:0] {
        ROW_NONE,     // no word expected
        ROW_WORD,     // word typed into the table
        ROW_PREDICT   // word worked out by take_sample
    } row_check_t;

    typedef struct {
        row_op_t                op;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
        row_check_t             check;
        kind_t                  kind;
        logic [AVG_W-1:0]       average;
    } row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    sample    = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   kind;
    logic [AVG_W-1:0]       average;

    // Shadow of the unit's registers and running state, kept in step with
    // every accepted sample and every register write.
    logic [THRESH_W-1:0]    shadow_threshold    = THRESH_RESET;
    logic [IVL_W-1:0]       shadow_interval     = IVL_RESET;
    logic [SUM_W-1:0]       running_sum         = '0;
    logic [CNT_W-1:0]       samples_in_block    = '0;
    logic [IVL_W-1:0]       averages_since_send = SINCE_RESET;

    result_word_t           result_words_due[$];
    int                     mismatch_count = 0;
    int                     quiet_cycles   = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;
    int                     hold_left      = 0;
    logic                   hold_token     = 1'b0;
    logic                   hold_seen      = 1'b0;
    row_t                   directed_rows [ROWS];

    sample_threshold_alarm_block_averager_unit #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .average   (average)
    );

    always #1 clk = ~clk;

    // Alarm when ten times the sample is over the threshold; otherwise the
    // sample joins the block, and a full block (with a nonzero threshold)
    // yields sum / BLOCK_SIZE * 10, sent only on every interval-th block.
    function automatic bit take_sample(input logic [SAMPLE_W-1:0] value,
                                       output result_word_t word);
        int unsigned scaled;
        int unsigned quotient;
        scaled = value * SCALE;
        word = '{KIND_ALARM, '0};
        if (scaled > shadow_threshold)
            return 1'b1;
        // both wrap at their register widths
        running_sum = running_sum + value;
        samples_in_block = samples_in_block + 1'b1;
        if (samples_in_block == BLOCK_SIZE && shadow_threshold != '0)
        begin
            quotient = running_sum / BLOCK_SIZE;
            running_sum = '0;
            samples_in_block = '0;
            if (averages_since_send >= shadow_interval)
            begin
                averages_since_send = SINCE_RESET;
                word.kind = KIND_AVERAGE;
                word.average = AVG_W'(quotient * SCALE);
                return 1'b1;
            end
            averages_since_send = averages_since_send + 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    // Offer one sample word, holding it until taken. Valid is only lowered
    // while idling, so back-to-back words keep it high.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value,
                               input row_check_t check,
                               input result_word_t typed);
        result_word_t word;
        bit produced;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        produced = take_sample(value, word);
        case (check)
            ROW_PREDICT: if (produced) result_words_due.push_back(word);
            ROW_WORD:    result_words_due.push_back(typed);
            default:     ;
        endcase
    endtask

    // Sender stops until every owed word is out, then lets the pipe settle
    // (a sample with no word may still be in flight).
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (result_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        pause_until_drained();
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == REG_THRESHOLD)
            shadow_threshold = (value > THRESH_CLAMP) ? THRESH_CLAMP : value;
        else if (index == REG_INTERVAL)
            shadow_interval = value[IVL_W-1:0];
    endtask

    // In-range samples but for alarm_pct percent, so blocks complete; the rest anywhere in the
    // 12-bit range, which mostly raises alarms.
    task automatic run_phase(input int count, input int alarm_pct);
        logic [SAMPLE_W-1:0] value;
        repeat (count)
        begin
            if ($urandom_range(99) < alarm_pct)
                value = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            else
                value = SAMPLE_W'($urandom_range(int'(shadow_threshold) / SCALE));
            send_sample(value, ROW_PREDICT, '0);
        end
    endtask

    // Output side: check each taken word against the oldest one owed, then
    // pick the stall for the next cycle. A toggle of hold_token starts a
    // long hold-off counted here.
    always @(posedge clk)
    begin : collect_words
        result_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_words_due.size() == 0)
                flag_mismatch($sformatf("unexpected word kind %0d average %0d",
                                        kind, average));
            else
            begin
                want = result_words_due.pop_front();
                if (kind !== want.kind)
                    flag_mismatch($sformatf("kind expected %0d actual %0d",
                                            want.kind, kind));
                if (average !== want.average)
                    flag_mismatch($sformatf("average expected %0d actual %0d",
                                            want.average, average));
            end
        end
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: too long with no word moving on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_sample_threshold_alarm_block_averager_unit: errors");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed table: alarm edges, clamping, masking, ignored indexes,
        // zero and unit thresholds.
        directed_rows = '{
            '{OP_SAMPLE, REG_THRESHOLD, 12'd4095,  ROW_WORD,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd401,   ROW_WORD,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd400,   ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd0,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'hAAA,   ROW_WORD,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'h555,   ROW_WORD,    KIND_ALARM, 16'd0},
            // all-ones threshold clamps to 1800
            '{OP_WRITE,  REG_THRESHOLD, 12'hFFF,   ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd181,   ROW_WORD,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd180,   ROW_NONE,    KIND_ALARM, 16'd0},
            // spare indexes must not touch the threshold
            '{OP_WRITE,  REG_SPARE_A,   12'd0,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd1,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_WRITE,  REG_SPARE_B,   12'hFFF,   ROW_NONE,    KIND_ALARM, 16'd0},
            // interval masked to 10 bits
            '{OP_WRITE,  REG_INTERVAL,  12'hFFF,   ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_WRITE,  REG_THRESHOLD, 12'd0,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd1,     ROW_WORD,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd0,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_WRITE,  REG_THRESHOLD, 12'd1,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd1,     ROW_WORD,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd0,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_WRITE,  REG_THRESHOLD, 12'd1801,  ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'd180,   ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_WRITE,  REG_INTERVAL,  12'd0,     ROW_NONE,    KIND_ALARM, 16'd0},
            '{OP_SAMPLE, REG_THRESHOLD, 12'h800,   ROW_PREDICT, KIND_ALARM, 16'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often, receiver more so
        send_idle_pct = 35;
        recv_idle_pct = 49;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == OP_WRITE)
                write_register(directed_rows[i].index, directed_rows[i].value);
            else
                send_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].check,
                            '{directed_rows[i].kind, directed_rows[i].average});
        end

        // plain blocks, every average sent
        write_register(REG_THRESHOLD, 12'd1800);
        write_register(REG_INTERVAL, 12'd1);
        run_phase(120, 15);

        // interval zero sends every average too
        write_register(REG_INTERVAL, 12'd0);
        write_register(REG_THRESHOLD, CFG_DATA_W'($urandom_range(200, 1800)));
        run_phase(80, 20);

        write_register(REG_INTERVAL, 12'd3);
        run_phase(100, 10);

        // roles swapped
        send_idle_pct = 49;
        recv_idle_pct = 35;

        // widest interval: averages pile up unsent, then a small interval
        // lets the already-high counter fire at once
        write_register(REG_THRESHOLD, 12'd1800);
        write_register(REG_INTERVAL, 12'd1023);
        run_phase(100, 20);
        write_register(REG_INTERVAL, 12'd2);
        run_phase(60, 10);

        // receiver holds off while alarms keep coming: the pipe fills and
        // the input stalls; then the sender waits for every word
        write_register(REG_INTERVAL, 12'd1);
        hold_token <= ~hold_token;
        run_phase(80, 50);
        pause_until_drained();

        write_register(REG_THRESHOLD, CFG_DATA_W'($urandom_range(1, 50)));
        run_phase(60, 30);

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        write_register(REG_THRESHOLD, 12'd1800);
        write_register(REG_INTERVAL, 12'd0);
        run_phase(60, 15);

        // zero threshold: only zeros are taken and the count runs past
        // BLOCK_SIZE with no average formed
        write_register(REG_THRESHOLD, 12'd0);
        run_phase(60, 10);
        while (samples_in_block <= BLOCK_SIZE)
            send_sample('0, ROW_PREDICT, '0);

        pause_until_drained();
        repeat (2 * SETTLE) @(posedge clk);
        if (mismatch_count == 0 && result_words_due.size() == 0)
            $display("tb_sample_threshold_alarm_block_averager_unit: clean");
        else
            $display("tb_sample_threshold_alarm_block_averager_unit: errors");
        $finish;
    end

endmodule
